// File: sv/snm_pkg.sv
// shared constants and types for the sobel / non-maximum suppression edge block
// no dependencies
package snm_pkg;

  // default sizes
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_LOW_THRESHOLD = 2'd2
  } reg_index_e;

  // register reset values and clamp limits
  localparam int WIDTH_RESET     = 640;
  localparam int HEIGHT_RESET    = 480;
  localparam int THRESHOLD_RESET = 180;
  localparam int SIZE_MIN        = 5;
  localparam int HEIGHT_MAX      = 4095;
  localparam int THR_W           = 11;
  localparam int THR_SQ_W        = 2 * THR_W;

  // direction quantization, tangents of 22.5 and 67.5 degrees in fixed point with 16 fraction bits
  localparam int TAN_LO    = 27146;
  localparam int TAN_HI    = 158218;
  localparam int FIX_SHIFT = 16;

  typedef enum logic [1:0] {
    DIR_0   = 2'd0,
    DIR_45  = 2'd1,
    DIR_90  = 2'd2,
    DIR_135 = 2'd3
  } dir_e;

  // root bits resolved per square root stage
  localparam int SQRT_STEPS_PER_STAGE = 3;

  // output geometry
  localparam int ROW_W = 12;
  localparam int COL_W = 10;

endpackage

// File: sv/snm_line_mem.sv
// single line store: one write port, one registered read port at the same address
// no dependencies
module snm_line_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents when the same address is written
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/snm_fsq.sv
// pipelined floored square: isqrt of a magnitude, then the root squared
// depends on snm_pkg
module snm_fsq #(
  parameter int VW = 21,
  parameter int PW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       in_valid_i,
  input  logic [VW-1:0]              in_val_i,
  input  logic [PW-1:0]              in_pay_i,
  output logic                       out_valid_o,
  output logic [VW-1:0]              out_val_o,
  output logic [2*((VW+1)/2)-1:0]    out_fsq_o,
  output logic [PW-1:0]              out_pay_o
);
  import snm_pkg::*;

  localparam int RW = (VW + 1) / 2;
  localparam int NS = (RW + SQRT_STEPS_PER_STAGE - 1) / SQRT_STEPS_PER_STAGE;
  localparam int XW = RW + 3;

  logic [XW-1:0] rem_q  [NS];
  logic [XW-1:0] rem_d  [NS];
  logic [RW-1:0] root_q [NS];
  logic [RW-1:0] root_d [NS];
  logic [VW-1:0] val_q  [NS];
  logic [PW-1:0] pay_q  [NS];
  logic          vld_q  [NS];

  logic [2*RW-1:0] fsq_q;
  logic [VW-1:0]   oval_q;
  logic [PW-1:0]   opay_q;
  logic            ovld_q;

  // restoring square root, two value bits per step
  always_comb begin
    logic [XW-1:0]   r;
    logic [XW-1:0]   t;
    logic [RW-1:0]   q;
    logic [2*RW-1:0] vp;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        r  = '0;
        q  = '0;
        vp = (2*RW)'(in_val_i);
      end else begin
        r  = rem_q[s-1];
        q  = root_q[s-1];
        vp = (2*RW)'(val_q[s-1]);
      end
      for (int j = 0; j < SQRT_STEPS_PER_STAGE; j++) begin
        if (s * SQRT_STEPS_PER_STAGE + j < RW) begin
          r = {r[XW-3:0], vp[2*(RW-1-(s*SQRT_STEPS_PER_STAGE+j)) +: 2]};
          t = {1'b0, q, 2'b01};
          if (r >= t) begin
            r = r - t;
            q = {q[RW-2:0], 1'b1};
          end else begin
            q = {q[RW-2:0], 1'b0};
          end
        end
      end
      rem_d[s]  = r;
      root_d[s] = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) begin
        vld_q[s] <= 1'b0;
      end
      ovld_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
      ovld_q <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q[0] <= in_val_i;
      pay_q[0] <= in_pay_i;
      for (int s = 1; s < NS; s++) begin
        val_q[s] <= val_q[s-1];
        pay_q[s] <= pay_q[s-1];
      end
      for (int s = 0; s < NS; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
      end
      fsq_q  <= (2*RW)'(root_q[NS-1]) * (2*RW)'(root_q[NS-1]);
      oval_q <= val_q[NS-1];
      opay_q <= pay_q[NS-1];
    end
  end

  assign out_valid_o = ovld_q;
  assign out_val_o   = oval_q;
  assign out_fsq_o   = fsq_q;
  assign out_pay_o   = opay_q;

endmodule

// File: sv/sobel_nonmax_edge_detector_core.sv
// top level of the sobel gradient and non-maximum suppression edge block
// depends on snm_pkg, snm_line_mem and snm_fsq
//
// Grey pixels stream in raster order, one item per clock, and one edge flag comes
// out per interior gradient position (0 edge, 1 background) with its gradient row
// and column; tlast marks the last result of a frame. The pipeline sustains one
// pixel per cycle; the rate is set by the single-port line stores, each read at
// most once and written at most once per pixel. From the pixel to its result the
// registers are: pixel store read, window, gradient, squares, magnitude, four
// square root stages, root squared, gradient store read, window, output register.
// A result waiting at the output stalls the whole pipeline. After reset the four
// line stores are cleared, one column per cycle, while no pixel is taken;
// configuration writes are taken at any time and must only be issued while the
// block is idle. Writing the image width or height restarts the frame at row 0,
// column 0.
module sobel_nonmax_edge_detector_core
  import snm_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: pixel
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: edge_flag, out_row, out_col
  output logic [23:0]                         m_axis_tdata,
  output logic                                m_axis_tlast,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [snm_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [snm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import snm_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int CW   = AW + 1;
  localparam int AXW  = PIXEL_BITS + 2;       // |gx|, |gy|
  localparam int GW   = PIXEL_BITS + 3;       // signed gx, gy
  localparam int SUMW = PIXEL_BITS + 2;       // weighted column sums
  localparam int SW   = 2 * AXW + 1;          // squared magnitude
  localparam int RW   = (SW + 1) / 2;
  localparam int FW   = 2 * RW;               // floored square
  localparam int EW   = FW + SW + 2;          // gradient store entry
  localparam int LW   = AXW + 18;             // direction compare width
  localparam int MW   = (FW > THR_SQ_W) ? FW : THR_SQ_W;

  typedef struct packed {
    logic            par;
    logic [ROW_W-1:0] pr;
    logic [AW-1:0]   pc;
    logic            grad;   // position yields a gradient
    logic            res;    // position yields a result
    logic            last;
  } tag_t;

  typedef struct packed {
    dir_e dir;
    tag_t tag;
  } fpay_t;

  // configuration
  logic [CW-1:0]       w_q;
  logic [ROW_W-1:0]    h_q;
  logic [THR_SQ_W-1:0] thr_sq_q;
  logic                cfg_wr;
  logic                size_wr;
  logic [12:0]         wclamp;
  logic [ROW_W-1:0]    hclamp;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign size_wr     = cfg_wr && (cfg_index_i == REG_IMAGE_WIDTH ||
                                  cfg_index_i == REG_IMAGE_HEIGHT);

  always_comb begin
    wclamp = {2'b00, cfg_data_i[10:0]};
    if (wclamp < 13'(SIZE_MIN)) begin
      wclamp = 13'(SIZE_MIN);
    end else if (wclamp > 13'(MAX_WIDTH)) begin
      wclamp = 13'(MAX_WIDTH);
    end
    hclamp = cfg_data_i[ROW_W-1:0];
    if (hclamp < ROW_W'(SIZE_MIN)) begin
      hclamp = ROW_W'(SIZE_MIN);
    end else if (hclamp > ROW_W'(HEIGHT_MAX)) begin
      hclamp = ROW_W'(HEIGHT_MAX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q      <= CW'(WIDTH_RESET);
      h_q      <= ROW_W'(HEIGHT_RESET);
      thr_sq_q <= THR_SQ_W'(THRESHOLD_RESET * THRESHOLD_RESET);
    end else if (cfg_wr) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:   w_q      <= wclamp[CW-1:0];
        REG_IMAGE_HEIGHT:  h_q      <= hclamp;
        REG_LOW_THRESHOLD: thr_sq_q <= THR_SQ_W'(cfg_data_i[THR_W-1:0]) *
                                       THR_SQ_W'(cfg_data_i[THR_W-1:0]);
        default: ;
      endcase
    end
  end

  // pipeline control: everything moves unless a result is stuck at the output
  logic en;
  logic accept;
  logic clr_q;
  logic [AW-1:0] clr_cnt_q;
  logic m_valid_q;

  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en && !clr_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // line store clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(MAX_WIDTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // raster position of the next pixel
  logic [AW-1:0]    pc_q;
  logic [ROW_W-1:0] pr_q;
  logic [CW-1:0]    pc_inc;

  assign pc_inc = {1'b0, pc_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      pr_q <= '0;
    end else if (size_wr) begin
      pc_q <= '0;
      pr_q <= '0;
    end else if (accept) begin
      if (pc_inc >= w_q) begin
        pc_q <= '0;
        if (pr_q + 1'b1 >= h_q) begin
          pr_q <= '0;
        end else begin
          pr_q <= pr_q + 1'b1;
        end
      end else begin
        pc_q <= pc_inc[AW-1:0];
      end
    end
  end

  // pixel line stores, one per row parity
  logic [PIXEL_BITS-1:0] pix;
  logic [PIXEL_BITS-1:0] prd [2];

  assign pix = s_axis_tdata[PIXEL_BITS-1:0];

  for (genvar k = 0; k < 2; k++) begin : g_pix_mem
    snm_line_mem #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (PIXEL_BITS)
    ) u_mem (
      .clk_i   (clk_i),
      .rd_en_i (accept),
      .wr_en_i (clr_q || (accept && pr_q[0] == k[0])),
      .addr_i  (clr_q ? clr_cnt_q : pc_q),
      .wdata_i (clr_q ? '0 : pix),
      .rdata_o (prd[k])
    );
  end

  // stage a: pixel taken, line store read under way
  logic                  a_vld_q;
  tag_t                  a_tag_q;
  logic [PIXEL_BITS-1:0] a_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_pix_q      <= pix;
      a_tag_q.par  <= pr_q[0];
      a_tag_q.pr   <= pr_q;
      a_tag_q.pc   <= pc_q;
      a_tag_q.grad <= pr_q >= ROW_W'(2) && pc_q >= AW'(2);
      a_tag_q.res  <= pr_q >= ROW_W'(4) && pc_q >= AW'(4);
      a_tag_q.last <= (pr_q == h_q - 1'b1) && ({1'b0, pc_q} == w_q - 1'b1);
    end
  end

  // stage b: 3x3 pixel window
  logic [PIXEL_BITS-1:0] pw_q [3][3];
  logic                  b_vld_q;
  tag_t                  b_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pw_q[r][c] <= '0;
        end
      end
    end else if (en) begin
      b_vld_q <= a_vld_q;
      if (a_vld_q) begin
        for (int r = 0; r < 3; r++) begin
          pw_q[r][0] <= pw_q[r][1];
          pw_q[r][1] <= pw_q[r][2];
        end
        // top row is the older line of the same parity
        pw_q[0][2] <= a_tag_q.par ? prd[1] : prd[0];
        pw_q[1][2] <= a_tag_q.par ? prd[0] : prd[1];
        pw_q[2][2] <= a_pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_tag_q <= a_tag_q;
    end
  end

  // stage c: sobel gradient and its absolute values
  logic [SUMW-1:0]  sum_r, sum_l, sum_b, sum_t;
  logic signed [GW-1:0] gx, gy;
  logic             c_vld_q;
  tag_t             c_tag_q;
  logic [AXW-1:0]   c_ax_q, c_ay_q;
  logic             c_xpos_q, c_ypos_q;

  assign sum_r = SUMW'(pw_q[0][2]) + SUMW'({pw_q[1][2], 1'b0}) + SUMW'(pw_q[2][2]);
  assign sum_l = SUMW'(pw_q[0][0]) + SUMW'({pw_q[1][0], 1'b0}) + SUMW'(pw_q[2][0]);
  assign sum_b = SUMW'(pw_q[2][0]) + SUMW'({pw_q[2][1], 1'b0}) + SUMW'(pw_q[2][2]);
  assign sum_t = SUMW'(pw_q[0][0]) + SUMW'({pw_q[0][1], 1'b0}) + SUMW'(pw_q[0][2]);
  assign gx    = signed'({1'b0, sum_r}) - signed'({1'b0, sum_l});
  assign gy    = signed'({1'b0, sum_b}) - signed'({1'b0, sum_t});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_tag_q  <= b_tag_q;
      c_ax_q   <= gx[GW-1] ? AXW'(-gx) : AXW'(gx);
      c_ay_q   <= gy[GW-1] ? AXW'(-gy) : AXW'(gy);
      c_xpos_q <= !gx[GW-1] && (gx != '0);
      c_ypos_q <= !gy[GW-1] && (gy != '0);
    end
  end

  // stage d: squares and tangent products
  logic             d_vld_q;
  tag_t             d_tag_q;
  logic [2*AXW-1:0] d_sqx_q, d_sqy_q;
  logic [LW-1:0]    d_lo_q, d_hi_q;
  logic [AXW-1:0]   d_ay_q;
  logic             d_xpos_q, d_ypos_q, d_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_tag_q  <= c_tag_q;
      d_sqx_q  <= (2*AXW)'(c_ax_q) * (2*AXW)'(c_ax_q);
      d_sqy_q  <= (2*AXW)'(c_ay_q) * (2*AXW)'(c_ay_q);
      d_lo_q   <= LW'(c_ax_q) * LW'(TAN_LO);
      d_hi_q   <= LW'(c_ax_q) * LW'(TAN_HI);
      d_ay_q   <= c_ay_q;
      d_xpos_q <= c_xpos_q;
      d_ypos_q <= c_ypos_q;
      d_zero_q <= (c_ax_q == '0) && (c_ay_q == '0);
    end
  end

  // stage e: magnitude and quantized direction
  logic [LW-1:0] ay_fix;
  dir_e          dir;
  logic          e_vld_q;
  tag_t          e_tag_q;
  logic [SW-1:0] e_s_q;
  dir_e          e_dir_q;

  assign ay_fix = LW'(d_ay_q) << FIX_SHIFT;

  always_comb begin
    if (d_zero_q || ay_fix < d_lo_q) begin
      dir = DIR_0;
    end else if (ay_fix > d_hi_q) begin
      dir = DIR_90;
    end else if (d_xpos_q == d_ypos_q) begin
      dir = DIR_45;
    end else begin
      dir = DIR_135;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_tag_q <= d_tag_q;
      e_s_q   <= SW'(d_sqx_q) + SW'(d_sqy_q);
      e_dir_q <= dir;
    end
  end

  // floored square of the magnitude, stored with the gradient for its neighbours
  fpay_t         e_pay;
  fpay_t         f_pay;
  logic          f_vld;
  logic [SW-1:0] f_s;
  logic [FW-1:0] f_fsq;

  assign e_pay.dir = e_dir_q;
  assign e_pay.tag = e_tag_q;

  snm_fsq #(
    .VW (SW),
    .PW ($bits(fpay_t))
  ) u_fsq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (e_vld_q),
    .in_val_i    (e_s_q),
    .in_pay_i    (e_pay),
    .out_valid_o (f_vld),
    .out_val_o   (f_s),
    .out_fsq_o   (f_fsq),
    .out_pay_o   (f_pay)
  );

  // gradient line stores, one per row parity
  logic [EW-1:0] f_ent;
  logic [AW-1:0] gc;
  logic          g_take;
  logic [EW-1:0] grd [2];

  assign f_ent  = {f_fsq, f_s, f_pay.dir};
  assign gc     = f_pay.tag.pc - AW'(2);
  assign g_take = en && f_vld && f_pay.tag.grad;

  for (genvar k = 0; k < 2; k++) begin : g_grad_mem
    snm_line_mem #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (EW)
    ) u_mem (
      .clk_i   (clk_i),
      .rd_en_i (g_take),
      .wr_en_i (clr_q || (g_take && f_pay.tag.par == k[0])),
      .addr_i  (clr_q ? clr_cnt_q : gc),
      .wdata_i (clr_q ? '0 : f_ent),
      .rdata_o (grd[k])
    );
  end

  // stage g: gradient store read under way
  logic          g_vld_q;
  tag_t          g_tag_q;
  logic [EW-1:0] g_ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (en) begin
      g_vld_q <= f_vld && f_pay.tag.grad;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_tag_q <= f_pay.tag;
      g_ent_q <= f_ent;
    end
  end

  // stage h: 3x3 gradient window
  logic [EW-1:0] gw_q [3][3];
  logic          h_vld_q;
  tag_t          h_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          gw_q[r][c] <= '0;
        end
      end
    end else if (en) begin
      h_vld_q <= g_vld_q && g_tag_q.res;
      if (g_vld_q) begin
        for (int r = 0; r < 3; r++) begin
          gw_q[r][0] <= gw_q[r][1];
          gw_q[r][1] <= gw_q[r][2];
        end
        gw_q[0][2] <= g_tag_q.par ? grd[1] : grd[0];
        gw_q[1][2] <= g_tag_q.par ? grd[0] : grd[1];
        gw_q[2][2] <= g_ent_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_tag_q <= g_tag_q;
    end
  end

  // non-maximum suppression on the window centre
  logic [EW-1:0] na, nb;
  logic [MW-1:0] cs, na_fsq, nb_fsq, thr;
  logic          edge_hit;

  always_comb begin
    case (dir_e'(gw_q[1][1][1:0]))
      DIR_0: begin
        na = gw_q[1][0];
        nb = gw_q[1][2];
      end
      DIR_45: begin
        na = gw_q[0][0];
        nb = gw_q[2][2];
      end
      DIR_90: begin
        na = gw_q[0][1];
        nb = gw_q[2][1];
      end
      default: begin
        na = gw_q[0][2];
        nb = gw_q[2][0];
      end
    endcase
  end

  assign cs       = MW'(gw_q[1][1][SW+1:2]);
  assign na_fsq   = MW'(na[EW-1:SW+2]);
  assign nb_fsq   = MW'(nb[EW-1:SW+2]);
  assign thr      = MW'(thr_sq_q);
  assign edge_hit = (cs > thr) && (cs > na_fsq) && (cs > nb_fsq);

  // output register
  logic             m_flag_q;
  logic [ROW_W-1:0] m_row_q;
  logic [COL_W-1:0] m_col_q;
  logic             m_last_q;
  logic [12:0]      col_full;

  assign col_full = 13'(h_tag_q.pc) - 13'd3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_flag_q <= !edge_hit;
      m_row_q  <= h_tag_q.pr - ROW_W'(3);
      m_col_q  <= col_full[COL_W-1:0];
      m_last_q <= h_tag_q.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_col_q, m_row_q, m_flag_q};
  assign m_axis_tlast  = m_last_q;

  // checks
  logic [12:0] wm4;
  assign wm4 = 13'(w_q) - 13'd4;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready)
    else $error("pixel taken during line store clearing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, pc_q} < w_q) && (pr_q < h_q))
    else $error("raster position outside the image");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_col_q == wm4[COL_W-1:0])
    else $error("frame end on a column other than the last gradient column");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_row_q != '0)
    else $error("result reported on the top border row");

endmodule
